// ===== sv/circle_octant_point_generator_defines.svh =====
// assertion helpers for the rtl file that checks itself (cop_back)
`ifndef CIRCLE_OCTANT_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_OCTANT_POINT_GENERATOR_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define COP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define COP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cop_pkg.sv =====
package cop_pkg;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // width of an output coordinate
  localparam int PT_W = 12;

  // decision variable constants of the Bresenham circle scheme
  localparam int DEC_INIT      = 3;
  localparam int DEC_STEP_DIAG = 10;
  localparam int DEC_STEP_AXIS = 6;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // points in one step
  localparam int OCT_POINTS = 8;
  localparam int OCT_IDX_W  = $clog2(OCT_POINTS);
  localparam logic [OCT_IDX_W-1:0] OCT_LAST = OCT_IDX_W'(OCT_POINTS - 1);

  typedef struct packed {
    logic full;
    logic empty;
  } cop_qstat_t;

endpackage

// ===== sv/cop_front.sv =====
module cop_front import cop_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int JOB_W = 1 + 2 * COORD_BITS + 2 * (COORD_BITS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [9:0]       in_center_x,
  input  logic [9:0]       in_center_y,
  input  logic [9:0]       in_radius,
  input  cop_qstat_t       q_stat,
  output logic             q_push,
  output logic [JOB_W-1:0] q_job
);

  localparam int XW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 6;

  logic [COORD_BITS-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [XW-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [XW-1:0]  x_inc, y_dec;
  logic signed [DW-1:0]  d_r, d_nxt;
  logic                  active_r, active_nxt;
  logic [COORD_BITS-1:0] rad;
  logic                  accept;
  logic                  can_plot;
  logic                  diag;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign rad      = COORD_BITS'(in_radius);
  assign can_plot = active_r && !(y_r < x_r);
  assign diag     = d_r > 0;
  assign x_inc    = x_r + XW'(1);
  assign y_dec    = y_r - XW'(1);

  // a step job carries its own copy of center and offsets
  assign q_push = accept && (in_cmd == CMD_STEP);
  assign q_job  = {!can_plot, cx_r, cy_r, x_r, y_r};

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    if (accept) begin
      if (in_cmd == CMD_START) begin
        cx_nxt     = COORD_BITS'(in_center_x);
        cy_nxt     = COORD_BITS'(in_center_y);
        x_nxt      = '0;
        y_nxt      = XW'(rad);
        d_nxt      = DW'(DEC_INIT) - (DW'(rad) << 1);
        active_nxt = 1'b1;
      end else if (can_plot) begin
        x_nxt = x_inc;
        if (diag) begin
          y_nxt = y_dec;
          d_nxt = d_r + ((DW'(x_inc) - DW'(y_dec)) << 2) + DW'(DEC_STEP_DIAG);
        end else begin
          d_nxt = d_r + (DW'(x_inc) << 2) + DW'(DEC_STEP_AXIS);
        end
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== sv/cop_queue.sv =====
module cop_queue import cop_pkg::*; #(
  parameter int WIDTH = 45
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output cop_qstat_t       stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = count_r == CW'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/cop_back.sv =====
`include "circle_octant_point_generator_defines.svh"

module cop_back import cop_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int JOB_W = 1 + 2 * COORD_BITS + 2 * (COORD_BITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [JOB_W-1:0]       q_head,
  input  cop_qstat_t             q_stat,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [PT_W-1:0] out_point_x,
  output logic signed [PT_W-1:0] out_point_y,
  output logic                   out_last_of_step,
  output logic                   out_finished
);

  localparam int XW = COORD_BITS + 1;
  localparam int WW = (COORD_BITS + 2 > PT_W) ? COORD_BITS + 2 : PT_W;

  logic                  job_fin;
  logic [COORD_BITS-1:0] job_cx, job_cy;
  logic signed [XW-1:0]  job_x, job_y;
  logic signed [XW-1:0]  off_a, off_b;
  logic [WW-1:0]         sum_x, sum_y;

  logic [OCT_IDX_W-1:0]  idx_r, idx_nxt;
  logic                  valid_r, valid_nxt;
  logic signed [PT_W-1:0] px_r, py_r;
  logic                  last_r, fin_r;
  logic                  load_ok, emit, end_of_job;

  assign {job_fin, job_cx, job_cy, job_x, job_y} = q_head;

  // idx bit 2 swaps x and y, bit 0 negates the x term, bit 1 the y term
  assign off_a = idx_r[2] ? job_y : job_x;
  assign off_b = idx_r[2] ? job_x : job_y;
  assign sum_x = idx_r[0] ? WW'(job_cx) - WW'(off_a) : WW'(job_cx) + WW'(off_a);
  assign sum_y = idx_r[1] ? WW'(job_cy) - WW'(off_b) : WW'(job_cy) + WW'(off_b);

  assign load_ok    = !valid_r || out_ready;
  assign emit       = load_ok && !q_stat.empty;
  assign end_of_job = job_fin || (idx_r == OCT_LAST);
  assign q_pop      = emit && end_of_job;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
      idx_nxt   = end_of_job ? '0 : idx_r + OCT_IDX_W'(1);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      px_r   <= job_fin ? '0 : sum_x[PT_W-1:0];
      py_r   <= job_fin ? '0 : sum_y[PT_W-1:0];
      last_r <= end_of_job;
      fin_r  <= job_fin;
    end
  end

  assign out_valid        = valid_r;
  assign out_point_x      = px_r;
  assign out_point_y      = py_r;
  assign out_last_of_step = last_r;
  assign out_finished     = fin_r;

  `COP_ASSERT_SAME(a_mid_step_job_held, idx_r != '0, !q_stat.empty,
    "job left the queue in the middle of a step")
  `COP_ASSERT_SAME(a_fin_single_beat, !q_stat.empty && job_fin, idx_r == '0,
    "finished job seen part way through a step")
  `COP_ASSERT_NEXT(a_pop_marks_last, q_pop, valid_r && last_r,
    "job retired without a last beat")
  `COP_ASSERT_SAME(a_fin_is_last, valid_r && fin_r, last_r,
    "finished beat not marked last")

endmodule

// ===== sv/circle_octant_point_generator.sv =====
// Step-driven Bresenham circle rasterizer. A start beat (cmd 0) latches center and radius
// and returns nothing. Each step beat (cmd 1) returns the eight symmetric points of the
// current offset, one result beat per cycle while out_ready stays high, the eighth marked
// last_of_step; once the octant is done a step returns a single beat with finished and
// last_of_step set and zero coordinates. A step therefore occupies the result port for
// eight beats and a finished step for one: the single result port paces the block.
// Commands are classified and the decision variable updated in the front end the
// cycle they are accepted; a two-entry job queue holds the step being streamed out
// until its last beat, so the front end can take one more step while the back end is
// still streaming points out.
module circle_octant_point_generator import cop_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [9:0]             in_center_x,
  input  logic [9:0]             in_center_y,
  input  logic [9:0]             in_radius,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [PT_W-1:0] out_point_x,
  output logic signed [PT_W-1:0] out_point_y,
  output logic                   out_last_of_step,
  output logic                   out_finished
);

  localparam int JOB_W = 1 + 2 * COORD_BITS + 2 * (COORD_BITS + 1);

  cop_qstat_t       q_stat;
  logic             q_push, q_pop;
  logic [JOB_W-1:0] q_job, q_head;

  cop_front #(
    .COORD_BITS(COORD_BITS),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius  (in_radius),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  cop_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  cop_back #(
    .COORD_BITS(COORD_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last_of_step(out_last_of_step),
    .out_finished    (out_finished)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import cop_pkg::*;

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   last;
    logic                   fin;
  } circle_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_START;
  logic [9:0] in_center_x = '0;
  logic [9:0] in_center_y = '0;
  logic [9:0] in_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PT_W-1:0] out_point_x;
  logic signed [PT_W-1:0] out_point_y;
  logic out_last_of_step;
  logic out_finished;

  // private copy of the rasterizer state
  logic [9:0]         circ_cx;
  logic [9:0]         circ_cy;
  logic signed [10:0] circ_ox;
  logic signed [10:0] circ_oy;
  logic signed [15:0] circ_dec;
  logic               circ_active;

  circle_point_t expected_points[$];
  int err_count = 0;
  int beats_sent = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  circle_octant_point_generator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_finished     (out_finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_point(input int px, input int py, input logic last, input logic fin);
    circle_point_t p;
    p.px = px[PT_W-1:0];
    p.py = py[PT_W-1:0];
    p.last = last;
    p.fin = fin;
    expected_points.push_back(p);
  endtask

  task automatic predict_circle_beat(input logic cmd, input logic [9:0] cx_in,
                                     input logic [9:0] cy_in, input logic [9:0] r_in);
    int cx, cy, x, y, d;
    if (cmd == CMD_START) begin
      circ_cx = cx_in;
      circ_cy = cy_in;
      circ_ox = '0;
      circ_oy = {1'b0, r_in};
      d = DEC_INIT - 2 * int'(r_in);
      circ_dec = d[15:0];
      circ_active = 1'b1;
    end else if (!circ_active || circ_oy < circ_ox) begin
      circ_active = 1'b0;
      push_point(0, 0, 1'b1, 1'b1);
    end else begin
      cx = int'(circ_cx);
      cy = int'(circ_cy);
      x = int'(circ_ox);
      y = int'(circ_oy);
      push_point(cx + x, cy + y, 1'b0, 1'b0);
      push_point(cx - x, cy + y, 1'b0, 1'b0);
      push_point(cx + x, cy - y, 1'b0, 1'b0);
      push_point(cx - x, cy - y, 1'b0, 1'b0);
      push_point(cx + y, cy + x, 1'b0, 1'b0);
      push_point(cx - y, cy + x, 1'b0, 1'b0);
      push_point(cx + y, cy - x, 1'b0, 1'b0);
      push_point(cx - y, cy - x, 1'b1, 1'b0);
      // decision update uses the already advanced offsets
      x = x + 1;
      if (circ_dec > 0) begin
        y = y - 1;
        d = int'(circ_dec) + 4 * (x - y) + DEC_STEP_DIAG;
      end else begin
        d = int'(circ_dec) + 4 * x + DEC_STEP_AXIS;
      end
      circ_ox = x[10:0];
      circ_oy = y[10:0];
      circ_dec = d[15:0];
    end
  endtask

  task automatic send_beat(input logic cmd, input logic [9:0] cx, input logic [9:0] cy,
                           input logic [9:0] r);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    do @(posedge clk); while (!in_ready);
    predict_circle_beat(cmd, cx, cy, r);
    beats_sent++;
  endtask

  task automatic send_step();
    send_beat(CMD_STEP, 10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  // result side: random stall before each beat, none while out_burst is set
  initial begin : result_sink
    int stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    circle_point_t got;
    circle_point_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_point_x, out_point_y, out_last_of_step, out_finished};
      if (expected_points.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected beat: x=%0d y=%0d last=%0b fin=%0b",
                   got.px, got.py, got.last, got.fin);
      end else begin
        want = expected_points.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.last !== want.last ||
            got.fin !== want.fin) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: exp x=%0d y=%0d last=%0b fin=%0b, ",
                      "got x=%0d y=%0d last=%0b fin=%0b"},
                     want.px, want.py, want.last, want.fin,
                     got.px, got.py, got.last, got.fin);
        end
      end
    end
  end

  // steps on an empty block after reset
  task automatic test_step_unloaded();
    send_step();
  endtask

  // zero radius: eight copies of the center, then done twice
  task automatic test_zero_radius();
    send_beat(CMD_START, 10'd512, 10'd300, 10'd0);
    repeat (3) send_step();
  endtask

  // corner centers with the largest radius, second start lands mid-circle
  task automatic test_extremes();
    send_beat(CMD_START, 10'd0, 10'd0, 10'd1023);
    repeat (3) send_step();
    send_beat(CMD_START, 10'd1023, 10'd1023, 10'd1023);
    repeat (3) send_step();
  endtask

  // small circles run to completion and beyond
  task automatic test_small_circles();
    out_burst = 1'b1;
    in_burst = 1'b1;
    send_beat(CMD_START, 10'd1, 10'd1022, 10'd1);
    repeat (3) send_step();
    out_burst = 1'b0;
    in_burst = 1'b0;
    send_beat(CMD_START, 10'd700, 10'd5, 10'd3);
    repeat (4) send_step();
  endtask

  task automatic test_random();
    int first;
    int pick;
    int cap;
    int n;
    logic [9:0] r;
    first = beats_sent;
    while (beats_sent - first < 105) begin
      if ($urandom_range(0, 5) == 0) in_burst = ~in_burst;
      if ($urandom_range(0, 5) == 0) out_burst = ~out_burst;
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        // well-formed circle, mostly small, sometimes cut short by a restart
        if (pick < 6) begin
          r = 10'($urandom_range(0, 12));
          cap = 12;
        end else begin
          r = 10'($urandom);
          cap = $urandom_range(1, 4);
        end
        send_beat(CMD_START, 10'($urandom), 10'($urandom), r);
        n = 0;
        while (circ_active && n < cap) begin
          send_step();
          n++;
        end
        if (!circ_active && $urandom_range(0, 1) == 1) send_step();
      end else begin
        send_beat(logic'($urandom_range(0, 1)), 10'($urandom), 10'($urandom),
                  10'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    circ_cx = '0;
    circ_cy = '0;
    circ_ox = '0;
    circ_oy = '0;
    circ_dec = '0;
    circ_active = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_step_unloaded();
    test_zero_radius();
    test_extremes();
    test_small_circles();
    test_random();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    // catch any stray beats after the last expected one
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cop_pkg.sv
sv/cop_front.sv
sv/cop_queue.sv
sv/cop_back.sv
sv/circle_octant_point_generator.sv
dv/tb.sv
